[design/vmt_pkg.sv]
// Shared types and constants for the vertex matrix transform block.
package vmt_pkg;

   localparam int ELEM_W            = 32;
   localparam int VEC_LEN           = 4;
   localparam int NUM_REGS          = 8;
   localparam int REG_W             = 64;
   localparam int CSR_INDEX_W       = 3;
   localparam int STAGES            = 4;
   localparam int FRAC_BITS_DEFAULT = 16;

   typedef struct packed {
      logic signed [ELEM_W-1:0] in_x;
      logic signed [ELEM_W-1:0] in_y;
      logic signed [ELEM_W-1:0] in_z;
      logic signed [ELEM_W-1:0] in_w;
      logic                     last_in;
   } req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] out_x;
      logic signed [ELEM_W-1:0] out_y;
      logic signed [ELEM_W-1:0] out_z;
      logic signed [ELEM_W-1:0] out_w;
      logic                     overflow;
      logic                     last_out;
   } rsp_type;

   // Per-stage load enables from the flow control to the datapath.
   typedef struct packed {
      logic [STAGES-1:0] load;
   } ctrl_type;

endpackage

[design/vmt_matrix_regs.sv]
// Matrix configuration registers, reset to the identity matrix.
module vmt_matrix_regs #(
   parameter int FRAC_BITS = vmt_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                                    clock,
   input  logic                                                    reset,
   input  logic                                                    csr_valid,
   output logic                                                    csr_ready,
   input  logic [vmt_pkg::CSR_INDEX_W-1:0]                         csr_index,
   input  logic [vmt_pkg::REG_W-1:0]                               csr_data,
   output logic [vmt_pkg::NUM_REGS-1:0][vmt_pkg::REG_W-1:0]        regs
);

   logic [vmt_pkg::NUM_REGS-1:0][vmt_pkg::REG_W-1:0] regs_ff;
   logic [vmt_pkg::NUM_REGS-1:0][vmt_pkg::REG_W-1:0] regs_in;
   logic [vmt_pkg::NUM_REGS-1:0][vmt_pkg::REG_W-1:0] regs_reset;

   localparam logic [vmt_pkg::REG_W-1:0] ONE = vmt_pkg::REG_W'(1) << FRAC_BITS;

   // Register k holds row k/2; the diagonal element sits in the half picked by the row.
   for (genvar k = 0; k < vmt_pkg::NUM_REGS; k++) begin : g_rst
      localparam int ROW = k / 2;
      localparam bit DIAG = ((k % 2) == (ROW / 2));
      assign regs_reset[k] = DIAG ? (ONE << (vmt_pkg::ELEM_W * (ROW % 2)))
                                  : '0;
   end

   assign csr_ready = 1'b1;

   always_comb begin
      regs_in = regs_ff;
      if (csr_valid) begin
         regs_in[csr_index] = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= regs_reset;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign regs = regs_ff;

endmodule

[design/vmt_flow.sv]
// Valid tracking and stall control for the transform pipeline.
module vmt_flow (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              last_in,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              last_out,
   output vmt_pkg::ctrl_type ctrl
);

   logic [vmt_pkg::STAGES-1:0] valid_ff;
   logic [vmt_pkg::STAGES-1:0] valid_in;
   logic [vmt_pkg::STAGES-1:0] last_ff;
   logic [vmt_pkg::STAGES-1:0] last_in_vec;
   logic [vmt_pkg::STAGES-1:0] stage_ready;

   // A stage may load when it is empty or its word moves on in the same cycle.
   always_comb begin
      stage_ready[vmt_pkg::STAGES-1] = !valid_ff[vmt_pkg::STAGES-1] || rsp_ready;
      for (int k = vmt_pkg::STAGES - 2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
   end

   always_comb begin
      valid_in    = valid_ff;
      last_in_vec = last_ff;
      if (stage_ready[0]) begin
         valid_in[0]    = req_valid;
         last_in_vec[0] = last_in;
      end
      for (int k = 1; k < vmt_pkg::STAGES; k++) begin
         if (stage_ready[k]) begin
            valid_in[k]    = valid_ff[k-1];
            last_in_vec[k] = last_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      last_ff <= last_in_vec;
   end

   assign ctrl.load = stage_ready;
   assign req_ready = stage_ready[0];
   assign rsp_valid = valid_ff[vmt_pkg::STAGES-1];
   assign last_out  = last_ff[vmt_pkg::STAGES-1];

endmodule

[design/vmt_column.sv]
// One output column: four products, an adder tree, shift and saturation.
module vmt_column #(
   parameter int FRAC_BITS = vmt_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                             clock,
   input  vmt_pkg::ctrl_type                                ctrl,
   input  logic [vmt_pkg::VEC_LEN-1:0][vmt_pkg::ELEM_W-1:0] vec,
   input  logic [vmt_pkg::VEC_LEN-1:0][vmt_pkg::ELEM_W-1:0] coef,
   output logic [vmt_pkg::ELEM_W-1:0]                       result,
   output logic                                             sat
);

   localparam int EW     = vmt_pkg::ELEM_W;
   localparam int PROD_W = 2 * EW;
   localparam int PAIR_W = PROD_W + 1;
   localparam int SUM_W  = PROD_W + 2;
   localparam logic [EW-1:0] MAX_VAL = {1'b0, {(EW-1){1'b1}}};
   localparam logic [EW-1:0] MIN_VAL = {1'b1, {(EW-1){1'b0}}};

   logic signed [PROD_W-1:0] prod_ff [vmt_pkg::VEC_LEN];
   logic signed [PROD_W-1:0] prod_in [vmt_pkg::VEC_LEN];
   logic signed [PAIR_W-1:0] pair_ff [2];
   logic signed [PAIR_W-1:0] pair_in [2];
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [SUM_W-1:0]  shifted;
   logic [SUM_W-EW:0]        head;
   logic [EW-1:0]            result_ff;
   logic [EW-1:0]            result_in;
   logic                     sat_ff;
   logic                     sat_in;

   always_comb begin
      for (int i = 0; i < vmt_pkg::VEC_LEN; i++) begin
         prod_in[i] = PROD_W'($signed(vec[i])) * PROD_W'($signed(coef[i]));
      end
      pair_in[0] = PAIR_W'(prod_ff[0]) + PAIR_W'(prod_ff[1]);
      pair_in[1] = PAIR_W'(prod_ff[2]) + PAIR_W'(prod_ff[3]);
      sum_in     = SUM_W'(pair_ff[0]) + SUM_W'(pair_ff[1]);
   end

   // Arithmetic shift is a floor; the result fits when all bits above the
   // low word's sign agree.
   assign shifted = sum_ff >>> FRAC_BITS;
   assign head    = shifted[SUM_W-1:EW-1];

   always_comb begin
      if (head == '0 || head == '1) begin
         result_in = shifted[EW-1:0];
         sat_in    = 1'b0;
      end else begin
         result_in = shifted[SUM_W-1] ? MIN_VAL : MAX_VAL;
         sat_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         prod_ff <= prod_in;
      end
      if (ctrl.load[1]) begin
         pair_ff <= pair_in;
      end
      if (ctrl.load[2]) begin
         sum_ff <= sum_in;
      end
      if (ctrl.load[3]) begin
         result_ff <= result_in;
         sat_ff    <= sat_in;
      end
   end

   assign result = result_ff;
   assign sat    = sat_ff;

endmodule

[design/vertex_matrix_transform.sv]
// Top level: homogeneous vertex times a configured 4x4 fixed-point matrix.
// A word accepted on req passes the product, pair-sum, sum and result registers in
// that order before it is offered on rsp.
// Throughput: one vertex per cycle unless rsp stalls; four-stage pipeline, 16 multipliers.
// On a result stall, full stages with no empty stage downstream hold; empty ones keep filling.
// Reset clears all pipeline valid bits and loads the identity matrix.
// Configuration writes complete in the cycle they are offered.
module vertex_matrix_transform #(
   parameter int FRAC_BITS = vmt_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  vmt_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output vmt_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [vmt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [vmt_pkg::REG_W-1:0]       csr_data
);

   localparam int EW = vmt_pkg::ELEM_W;
   localparam int VL = vmt_pkg::VEC_LEN;

   // Matrix storage: register 2*i + j/2 holds M[i][j], even column in the low word.
   logic [vmt_pkg::NUM_REGS-1:0][vmt_pkg::REG_W-1:0] regs;
   vmt_pkg::ctrl_type                                ctrl;
   logic [VL-1:0][EW-1:0]                            vec;
   logic [VL-1:0][EW-1:0]                            col_result;
   logic [VL-1:0]                                    col_sat;
   logic                                             last_out;

   vmt_matrix_regs #(
      .FRAC_BITS (FRAC_BITS)
   ) u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .regs      (regs)
   );

   // The flow block owns the valid bits and the last marker; the columns
   // carry only data and load whenever their stage may advance.
   vmt_flow u_flow (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .last_in   (req_data.last_in),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .last_out  (last_out),
      .ctrl      (ctrl)
   );

   assign vec[0] = req_data.in_x;
   assign vec[1] = req_data.in_y;
   assign vec[2] = req_data.in_z;
   assign vec[3] = req_data.in_w;

   // Each column sees the same vertex and its own column of the matrix.
   for (genvar j = 0; j < VL; j++) begin : g_col
      logic [VL-1:0][EW-1:0] coef;
      for (genvar i = 0; i < VL; i++) begin : g_row
         assign coef[i] = regs[2*i + j/2][EW*(j%2) +: EW];
      end
      vmt_column #(
         .FRAC_BITS (FRAC_BITS)
      ) u_column (
         .clock  (clock),
         .ctrl   (ctrl),
         .vec    (vec),
         .coef   (coef),
         .result (col_result[j]),
         .sat    (col_sat[j])
      );
   end

   assign rsp_data.out_x    = col_result[0];
   assign rsp_data.out_y    = col_result[1];
   assign rsp_data.out_z    = col_result[2];
   assign rsp_data.out_w    = col_result[3];
   assign rsp_data.overflow = |col_sat;
   assign rsp_data.last_out = last_out;

endmodule

[sim/tb_vertex_matrix_transform.sv]
// Self-checking testbench for the vertex matrix transform block.
`timescale 1ns / 100ps

module tb_vertex_matrix_transform;

   import vmt_pkg::*;

   // The block runs with its default fraction width, so 1.0 is 1 << FRAC.
   localparam int FRAC = FRAC_BITS_DEFAULT;
   localparam logic [31:0] UNIT = 32'(1) << FRAC;
   localparam logic [31:0] ELEM_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] ELEM_MIN = 32'h8000_0000;
   localparam logic [31:0] HALF = UNIT >> 1;
   // Saturation bounds, held at the width of the exact four-term sum.
   localparam logic signed [65:0] SUM_MAX = 66'sd2147483647;
   localparam logic signed [65:0] SUM_MIN = -66'sd2147483648;
   // A word taken on req passes every pipeline stage before it can leave on rsp.
   localparam int LATENCY = STAGES;
   localparam int DRAIN_LIMIT = 2000;
   localparam int LONG_STALL = 300;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS = 110;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [REG_W-1:0] csr_data = '0;

   // Vertices waiting to be offered, and transformed vertices still owed by the block.
   req_type pending_vertices[$];
   rsp_type expected_vertices[$];

   // The testbench's own copy of the eight matrix registers.
   logic [REG_W-1:0] matrix_regs[NUM_REGS];
   // Matrix that the next configuration phase loads, as plan[row][column].
   logic [31:0] matrix_plan[4][4];

   // Handshake results of the last rising edge, read by the falling-edge processes.
   logic req_accept_flag = 1'b0;
   logic csr_accept_flag = 1'b0;

   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   // Toggling this asks the receiver for one long hold-off.
   logic stall_armed = 1'b0;
   logic stall_seen = 1'b0;
   int stall_left = 0;

   int fail_count = 0;
   int rsp_seen = 0;

   vertex_matrix_transform #(
      .FRAC_BITS(FRAC)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Every failure goes through here: one line, one count.
   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                   rsp_seen, name, got, want));
   endtask

   // Row vector times the current matrix. Each product is exact, the four are summed
   // at 66 bits so that even (-2^31)^2 * 4 fits, and the arithmetic shift is a floor.
   function automatic rsp_type transform_vertex(input req_type v);
      logic signed [31:0] comp[4];
      logic signed [31:0] coef;
      logic signed [65:0] acc;
      logic signed [65:0] shifted;
      logic [31:0] res[4];
      logic [63:0] reg_word;
      logic ovf;
      rsp_type r;
      comp[0] = v.in_x;
      comp[1] = v.in_y;
      comp[2] = v.in_z;
      comp[3] = v.in_w;
      ovf = 1'b0;
      for (int j = 0; j < 4; j++) begin
         acc = '0;
         for (int i = 0; i < 4; i++) begin
            // Element [i][j] sits in register 2*i + j/2, odd columns in the upper half.
            reg_word = matrix_regs[2 * i + j / 2];
            coef = (j % 2 == 1) ? reg_word[63:32] : reg_word[31:0];
            acc = acc + comp[i] * coef;
         end
         shifted = acc >>> FRAC;
         if (shifted > SUM_MAX) begin
            res[j] = ELEM_MAX;
            ovf = 1'b1;
         end else if (shifted < SUM_MIN) begin
            res[j] = ELEM_MIN;
            ovf = 1'b1;
         end else begin
            res[j] = shifted[31:0];
         end
      end
      r.out_x = res[0];
      r.out_y = res[1];
      r.out_z = res[2];
      r.out_w = res[3];
      r.overflow = ovf;
      r.last_out = v.last_in;
      return r;
   endfunction

   // Rising edge: note what was accepted, predict, and check results in order.
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         matrix_regs[0] = 64'(UNIT);
         matrix_regs[1] = '0;
         matrix_regs[2] = 64'(UNIT) << 32;
         matrix_regs[3] = '0;
         matrix_regs[4] = '0;
         matrix_regs[5] = 64'(UNIT);
         matrix_regs[6] = '0;
         matrix_regs[7] = 64'(UNIT) << 32;
         req_accept_flag <= 1'b0;
         csr_accept_flag <= 1'b0;
      end else begin
         req_accept_flag <= req_valid && req_ready;
         csr_accept_flag <= csr_valid && csr_ready;
         // Writes only happen while no vertex is in flight, so the order of these
         // two updates never matters.
         if (csr_valid && csr_ready)
            matrix_regs[csr_index] = csr_data;
         if (req_valid && req_ready)
            expected_vertices.push_back(transform_vertex(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_vertices.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing expected",
                                         rsp_seen));
            end else begin
               want = expected_vertices.pop_front();
               compare_field("out_x", rsp_data.out_x, want.out_x);
               compare_field("out_y", rsp_data.out_y, want.out_y);
               compare_field("out_z", rsp_data.out_z, want.out_z);
               compare_field("out_w", rsp_data.out_w, want.out_w);
               compare_field("overflow", 32'(rsp_data.overflow), 32'(want.overflow));
               compare_field("last_out", 32'(rsp_data.last_out), 32'(want.last_out));
            end
            rsp_seen++;
         end
      end
   end

   // Falling edge: offer the next pending vertex once the current word has gone,
   // idling at random in between.
   always @(negedge clock) begin : vertex_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accept_flag) begin
         if (pending_vertices.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_data <= pending_vertices.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Falling edge: random back-pressure, plus one long hold-off on request so that
   // the pipeline fills and the block has to drop req_ready.
   always @(negedge clock) begin : result_sink
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_armed != stall_seen) begin
         stall_seen <= stall_armed;
         stall_left <= LONG_STALL;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic [31:0] w,
                              input logic last);
      req_type v;
      v.in_x = x;
      v.in_y = y;
      v.in_z = z;
      v.in_w = w;
      v.last_in = last;
      pending_vertices.push_back(v);
   endtask

   // Returns once every queued vertex has been accepted and transformed, then lets
   // the pipeline settle so that a following register write finds the block idle.
   task automatic wait_drained();
      int waited = 0;
      while (pending_vertices.size() != 0 || req_valid) begin
         @(posedge clock);
         #1;
      end
      while (expected_vertices.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         #1;
         waited++;
      end
      if (expected_vertices.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_vertices.size()));
         expected_vertices.delete();
      end
      repeat (LATENCY + 4) @(posedge clock);
      #1;
   endtask

   task automatic write_reg(input int index, input logic [REG_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_INDEX_W'(index);
      csr_data <= value;
      do @(negedge clock); while (!csr_accept_flag);
      csr_valid <= 1'b0;
   endtask

   // Writes all eight registers from matrix_plan.
   task automatic apply_matrix();
      for (int i = 0; i < 4; i++)
         for (int k = 0; k < 2; k++)
            write_reg(2 * i + k, {matrix_plan[i][2 * k + 1], matrix_plan[i][2 * k]});
      @(posedge clock);
      #1;
   endtask

   task automatic fill_matrix(input logic [31:0] value);
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++)
            matrix_plan[i][j] = value;
   endtask

   function automatic logic [31:0] pick_extreme();
      case ($urandom_range(4))
         0: return ELEM_MAX;
         1: return ELEM_MIN;
         2: return '0;
         3: return 32'hFFFF_FFFF;
         default: return UNIT;
      endcase
   endfunction

   // Matrix elements: modest transforms within +-8.0, raw bit patterns, extremes
   // and zeros, mixed in equal shares.
   function automatic logic [31:0] random_coef();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
         2: return pick_extreme();
         default: return '0;
      endcase
   endfunction

   // Vertex components: realistic coordinates half of the time, full range and
   // extremes often enough to reach saturation.
   function automatic logic [31:0] random_comp();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
         2: return pick_extreme();
         default: return 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      endcase
   endfunction

   initial begin : sequencer
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #1;
      sender_idle_pct = 25;
      receiver_idle_pct = 56;

      // Identity matrix straight out of reset: values must pass through untouched.
      send_vertex('0, '0, '0, '0, 1'b0);
      send_vertex(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX, 1'b1);
      send_vertex(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN, 1'b0);
      send_vertex(UNIT, -UNIT, UNIT + HALF, 32'hFFFF_FFFF, 1'b0);
      send_vertex(ELEM_MAX, ELEM_MIN, '0, 32'd1, 1'b1);
      wait_drained();

      // Largest positive elements: both directions of saturation.
      fill_matrix(ELEM_MAX);
      apply_matrix();
      send_vertex(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX, 1'b0);
      send_vertex(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN, 1'b1);
      send_vertex(UNIT, '0, '0, '0, 1'b0);
      send_vertex(32'd1, 32'd1, 32'd1, 32'd1, 1'b0);
      wait_drained();

      // Most negative elements: min times min is the largest exact sum there is.
      fill_matrix(ELEM_MIN);
      apply_matrix();
      send_vertex(ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN, 1'b0);
      send_vertex(ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX, 1'b1);
      send_vertex(ELEM_MAX, ELEM_MIN, ELEM_MAX, ELEM_MIN, 1'b0);
      send_vertex('0, '0, '0, 32'd1, 1'b0);
      wait_drained();

      // Every element 0.5: negative fractions must round toward minus infinity.
      fill_matrix(HALF);
      apply_matrix();
      send_vertex(32'hFFFF_FFFF, '0, '0, '0, 1'b0);
      send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0, 1'b0);
      send_vertex(32'd1, '0, '0, '0, 1'b1);
      send_vertex(32'hFFFF_FFFD, 32'd1, '0, '0, 1'b0);
      send_vertex(32'd3, 32'd3, 32'd3, 32'd1, 1'b1);
      wait_drained();

      // Random matrices and vertices. The first third idles the sender lightly and
      // the receiver heavily, the second the other way round, the last not at all.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p / 2)
            0: begin
               sender_idle_pct = 25;
               receiver_idle_pct = 56;
            end
            1: begin
               sender_idle_pct = 56;
               receiver_idle_pct = 25;
            end
            default: begin
               sender_idle_pct = 0;
               receiver_idle_pct = 0;
            end
         endcase
         for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
               matrix_plan[i][j] = random_coef();
         apply_matrix();
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_vertex(random_comp(), random_comp(), random_comp(), random_comp(),
                        ($urandom_range(7) == 0));
         // With the sender running flat out, a long receiver hold-off backs the
         // pipeline up until the block refuses new words.
         if (p == RANDOM_PHASES - 2)
            stall_armed = ~stall_armed;
         wait_drained();
      end

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Safety net: a hung handshake ends the run well past any correct finish.
   initial begin : watchdog
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

[sim.f]
design/vmt_pkg.sv
design/vmt_matrix_regs.sv
design/vmt_flow.sv
design/vmt_column.sv
design/vertex_matrix_transform.sv
sim/tb_vertex_matrix_transform.sv
